### sv/sepf_pkg.sv
// Shared types and constants for the skeleton end-point finder.
// Used by every module of the block except sepf_ram; no dependencies.
package sepf_pkg;

	// Field widths
	localparam int COUNT_W = 11;
	localparam int CFG_W   = 12;
	localparam int COORD_W = 13;

	// Default line store depth
	localparam int unsigned MAX_WIDTH_DEF = 1024;

	// Event queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QCNT_W  = $clog2(QDEPTH) + 1;

	// Register reset values
	localparam logic [COUNT_W-1:0] WIDTH_RST    = 11'd640;
	localparam logic [COUNT_W-1:0] HEIGHT_RST   = 11'd330;
	localparam logic [CFG_W-1:0]   OFFSET_X_RST = 12'd1290;
	localparam logic [CFG_W-1:0]   OFFSET_Y_RST = 12'd70;

	// Window sum of an end point: the pixel and its single neighbor
	localparam logic [3:0] END_SUM = 4'd2;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_OFFSET_X     = 2'd2,
		REG_OFFSET_Y     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_width;
		logic [COUNT_W-1:0] frame_height;
		logic [CFG_W-1:0]   offset_x;
		logic [CFG_W-1:0]   offset_y;
	} cfg_t;

	// One queued event: an end point, a frame end, or both
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               pt;
		logic               mk;
	} rec_t;

endpackage

### sv/sepf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sepf_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/sepf_front.sv
// Front part: pixel intake, raster counters, line store, 3x3 window and classification.
// Depends on sepf_pkg and sepf_ram.
module sepf_front #(
	parameter int unsigned MAX_WIDTH = sepf_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sepf_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        pixel_on,
	input  logic [sepf_pkg::QCNT_W-1:0] q_count,
	output logic                        push,
	output sepf_pkg::rec_t              push_rec
);
	import sepf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	function automatic logic [3:0] popcount9(input logic [8:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;
	logic [COUNT_W-1:0] col_q;
	logic [COUNT_W-1:0] row_q;
	logic               accept;
	logic               pad_col;
	logic               pad_row;

	logic               vld_s1;
	logic [COUNT_W-1:0] col_s1;
	logic [COUNT_W-1:0] row_s1;
	logic               pix_s1;
	logic               pad_col_s1;
	logic               pad_row_s1;

	logic [1:0]         rd_data;
	logic               mid;
	logic               top;
	logic [2:0]         col_bits;
	logic [8:0]         win_q;
	logic [8:0]         win_next;
	logic               pt;
	logic               mk;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [1:0]         ram_wdata;

	// Classify the arriving position against the frame size
	assign pad_col = (col_q >= cfg.frame_width) || (32'(col_q) >= MAX_WIDTH);
	assign pad_row = row_q >= cfg.frame_height;

	// Hold intake during the clear sweep and when the queue cannot take one more event
	assign in_stall = clr_busy_q || ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(vld_s1)
		>= (QCNT_W + 1)'(QDEPTH));
	assign accept = in_valid && !in_stall;

	// Clear sweep over the line store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Advance the raster counters on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				if (pad_col) begin
					col_q <= '0;
					row_q <= pad_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= col_q;
			row_s1     <= row_q;
			pix_s1     <= pixel_on && !pad_col && !pad_row;
			pad_col_s1 <= pad_col;
			pad_row_s1 <= pad_row;
		end
	end

	// Two rows of history per column: bit 0 one row up, bit 1 two rows up
	sepf_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(col_q)),
		.rdata(rd_data)
	);

	// Build the new window column; mask history on the first two rows
	assign mid      = (row_s1 != '0) && rd_data[0];
	assign top      = (row_s1 > COUNT_W'(1)) && rd_data[1];
	assign col_bits = pad_col_s1 ? 3'b000 : {pix_s1, mid, top};
	assign win_next = (col_s1 == '0) ? {col_bits, 6'b0} : {col_bits, win_q[8:3]};

	// Write back the shifted history, or zero during the clear sweep
	assign ram_we    = clr_busy_q || (vld_s1 && !pad_col_s1);
	assign ram_waddr = clr_busy_q ? clr_addr_q : AW'(col_s1);
	assign ram_wdata = clr_busy_q ? 2'b00 : {mid, pix_s1};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			win_q <= win_next;
		end
	end

	// End point: set center with exactly one set neighbor
	assign pt = vld_s1 && (col_s1 != '0) && (row_s1 != '0) && win_next[4]
		&& (popcount9(win_next) == END_SUM);
	assign mk = vld_s1 && pad_col_s1 && pad_row_s1;

	assign push       = pt || mk;
	assign push_rec.x = pt ? COORD_W'(col_s1) + COORD_W'(cfg.offset_x) - COORD_W'(1) : '0;
	assign push_rec.y = pt ? COORD_W'(row_s1) + COORD_W'(cfg.offset_y) - COORD_W'(1) : '0;
	assign push_rec.pt = pt;
	assign push_rec.mk = mk;

	// Nothing leaves the window while the line store is still being cleared
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !clr_busy_q)
		else $error("event pushed during line store clear");

	// Stage 1 only ever holds a pixel taken on the previous edge
	assert property (@(posedge clk) disable iff (!arst_n) vld_s1 |-> $past(accept))
		else $error("stage 1 valid without a transfer");

endmodule

### sv/sepf_queue.sv
// Short event queue between the front and back parts.
// Depends on sepf_pkg.
module sepf_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  sepf_pkg::rec_t              push_rec,
	input  logic                        pop,
	output sepf_pkg::rec_t              head,
	output logic                        q_valid,
	output logic [sepf_pkg::QCNT_W-1:0] count
);
	import sepf_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	rec_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head    = mem_q[rd_ptr_q];
	assign q_valid = count_q != '0;
	assign count   = count_q;

	// The front reserves room for every pixel in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (count_q == QCNT_W'(QDEPTH))))
		else $error("push into a full event queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> (count_q != '0))
		else $error("pop from an empty event queue");

endmodule

### sv/sepf_back.sv
// Back part: turns queued events into result transfers, end point before frame end.
// Depends on sepf_pkg.
module sepf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sepf_pkg::rec_t               head,
	input  logic                         q_valid,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sepf_pkg::COORD_W-1:0] end_x,
	output logic [sepf_pkg::COORD_W-1:0] end_y,
	output logic                         point_found,
	output logic                         frame_last
);
	import sepf_pkg::*;

	logic phase_q;
	logic emit_marker;
	logic xfer;

	// After the end point of a combined event, the frame end marker follows
	assign emit_marker = phase_q || !head.pt;
	assign out_valid   = q_valid;
	assign xfer        = out_valid && !out_stall;
	assign pop         = xfer && (emit_marker || !head.mk);

	assign end_x       = emit_marker ? '0 : head.x;
	assign end_y       = emit_marker ? '0 : head.y;
	assign point_found = !emit_marker;
	assign frame_last  = emit_marker;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (xfer) begin
			phase_q <= !emit_marker && head.mk;
		end
	end

	// The second half only exists for an event that carries both results
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (q_valid && head.pt && head.mk))
		else $error("marker phase without a combined event");

endmodule

### sv/skeleton_end_point_finder_unit.sv
// Top level of the skeleton end-point finder: configuration registers and part wiring.
// Depends on sepf_pkg, sepf_front, sepf_queue, sepf_back.

// Takes one binary pixel per clock while in_stall is low, in raster order, each row
// followed by one padding pixel and the frame followed by one padding row, so a frame is
// (frame_width+1)*(frame_height+1) transfers. Sustained rate is one pixel per cycle while
// in_stall is low; an end point (a set pixel with exactly one set neighbor in its 3x3
// window) is judged when the pixel one row down and one column right arrives, and with
// an empty event queue its result passes the stage 1 register and the event queue before
// it is presented on the output. Each frame closes with a bare marker result (frame_last
// set), after any end point found on the final pixel. After reset the line store memory
// is swept to zero, during which in_stall stays high. Configuration registers are read
// live, so write them only while no pixel is in flight. A short event queue sits between
// the window logic and the output, so the input keeps flowing while results wait on
// out_stall until the queued events plus the pixel in the window stage reach four.
module skeleton_end_point_finder_unit #(
	parameter int unsigned MAX_WIDTH = sepf_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [sepf_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         pixel_on,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sepf_pkg::COORD_W-1:0] end_x,
	output logic [sepf_pkg::COORD_W-1:0] end_y,
	output logic                         point_found,
	output logic                         frame_last
);
	import sepf_pkg::*;

	cfg_t              cfg_q;
	logic              push;
	rec_t              push_rec;
	logic              pop;
	rec_t              head;
	logic              q_valid;
	logic [QCNT_W-1:0] q_count;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= WIDTH_RST;
			cfg_q.frame_height <= HEIGHT_RST;
			cfg_q.offset_x     <= OFFSET_X_RST;
			cfg_q.offset_y     <= OFFSET_Y_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_wdata[COUNT_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_wdata[COUNT_W-1:0];
				REG_OFFSET_X:     cfg_q.offset_x     <= cfg_wdata;
				REG_OFFSET_Y:     cfg_q.offset_y     <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	sepf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_on(pixel_on),
		.q_count (q_count),
		.push    (push),
		.push_rec(push_rec)
	);

	sepf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head    (head),
		.q_valid (q_valid),
		.count   (q_count)
	);

	sepf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_valid    (q_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.end_x      (end_x),
		.end_y      (end_y),
		.point_found(point_found),
		.frame_last (frame_last)
	);

endmodule
